// ----- hdl/dwsp_pkg.sv -----
`default_nettype none

package dwsp_pkg;

  // One input word and one result word
  typedef struct packed {
    logic               kind;
    logic        [31:0] time_ms;
    logic signed [15:0] target_speed;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
  } item_t;

  typedef struct packed {
    logic [7:0] drive_left;
    logic [7:0] drive_right;
  } result_t;

  // Configuration port
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INT_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_MIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_DRIVE_MAX = 3'd5;

  localparam logic [15:0] GAIN_P_RST    = 16'd4096;
  localparam logic [15:0] GAIN_I_RST    = 16'd205;
  localparam logic [15:0] GAIN_D_RST    = 16'd205;
  localparam logic [14:0] INT_LIMIT_RST = 15'd800;
  localparam logic [7:0]  DRIVE_MIN_RST = 8'd40;
  localparam logic [7:0]  DRIVE_MAX_RST = 8'd200;

  // Datapath widths
  localparam int ERR_W  = 17;  // target minus measured speed
  localparam int DIFF_W = 18;  // error change
  localparam int INT_W  = 26;  // clamped integral, speed-ms
  localparam int LIM_W  = 25;  // integral limit times 1000
  localparam int INS_W  = 50;  // integral plus error times dt
  localparam int MUL_W  = 34;  // shared multiplier operands, signed
  localparam int PROD_W = 68;
  localparam int A_W    = 44;  // proportional plus integral numerator
  localparam int ACC_W  = 80;  // full numerator and division remainder
  localparam int DIV_W  = 66;  // divisor shifted for the quotient bits

  localparam int MS_PER_S  = 1000;
  localparam int MS_SQ     = 1000000;
  localparam int DRIVE_DEN = 65536000;

endpackage

`default_nettype wire

// ----- hdl/dual_wheel_speed_pid.sv -----
`default_nettype none

// Channel   Direction  Handshake                 Word
// item      in         item_valid / item_ready   dwsp_pkg::item_t
// result    out        result_valid / result_ready dwsp_pkg::result_t
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// A control update runs 20 steps per wheel on one 34x34 multiplier with a
// 1-bit-per-cycle quotient unit, plus load and emit. A loop reset word goes
// from load straight to emit. item_ready is high only while idle.
// The result register holds until taken; a finished word waits for it to drain.
// rst is synchronous and restores configuration and loop state.

module dual_wheel_speed_pid (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_ready,
  input  wire dwsp_pkg::item_t item,
  output logic               result_valid,
  input  wire                result_ready,
  output dwsp_pkg::result_t  result,
  input  wire                cfg_we,
  input  wire [dwsp_pkg::IDX_W-1:0] cfg_index,
  input  wire [dwsp_pkg::CFG_W-1:0] cfg_data
);
  import dwsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // Step codes name what each step consumes from the product register
  localparam logic [4:0] STEP_START   = 5'd0;
  localparam logic [4:0] STEP_INTEG   = 5'd1;
  localparam logic [4:0] STEP_KP      = 5'd2;
  localparam logic [4:0] STEP_A_P     = 5'd3;
  localparam logic [4:0] STEP_A_I     = 5'd4;
  localparam logic [4:0] STEP_D_SCALE = 5'd5;
  localparam logic [4:0] STEP_B       = 5'd6;
  localparam logic [4:0] STEP_N_LO    = 5'd7;
  localparam logic [4:0] STEP_N_HI    = 5'd8;
  localparam logic [4:0] STEP_DEN     = 5'd9;
  localparam logic [4:0] STEP_RANGE   = 5'd10;
  localparam logic [4:0] STEP_SAT     = 5'd19;

  logic [1:0]  state;
  logic [4:0]  step;
  logic        wheel;

  logic [15:0] gain_p, gain_i, gain_d;
  logic [14:0] integral_limit;
  logic [7:0]  drive_min, drive_max;

  logic [31:0] last_time;
  logic [31:0] d;
  logic [LIM_W-1:0] lim;

  logic signed [ERR_W-1:0] err   [2];
  logic signed [ERR_W-1:0] prev  [2];
  logic signed [INT_W-1:0] integ [2];
  logic        [7:0]       held  [2];

  logic signed [PROD_W-1:0] prod;
  logic signed [A_W-1:0]    acc_a;
  logic signed [ACC_W-1:0]  nacc;
  logic        [DIV_W-1:0]  dv;
  logic                     neg;
  logic                     over;
  logic        [7:0]        q;

  logic                     accept;
  logic        [31:0]       d_raw;
  logic        [31:0]       d_in;
  logic signed [ERR_W-1:0]  err_in_l, err_in_r;
  logic signed [ERR_W-1:0]  cur_err, cur_prev;
  logic signed [INT_W-1:0]  cur_integ;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  d_op;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [INS_W-1:0]  isum, lim_s, integ_clamp;
  logic                     div_ge;
  logic        [7:0]        sat_val;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  assign d_raw    = item.time_ms - last_time;
  assign d_in     = (d_raw == 32'd0) ? 32'd1 : d_raw;
  assign err_in_l = ERR_W'(item.target_speed) - ERR_W'(item.speed_left);
  assign err_in_r = ERR_W'(item.target_speed) - ERR_W'(item.speed_right);

  assign cur_err   = err[wheel];
  assign cur_prev  = prev[wheel];
  assign cur_integ = integ[wheel];
  assign diff      = DIFF_W'(cur_err) - DIFF_W'(cur_prev);
  assign d_op      = $signed({2'b00, d});

  // Shared multiplier operand select, one product per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      STEP_START: begin
        mul_a = MUL_W'(cur_err);
        mul_b = d_op;
      end
      STEP_INTEG: begin
        mul_a = $signed(MUL_W'(gain_p));
        mul_b = MUL_W'(MS_PER_S);
      end
      STEP_KP: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(cur_err);
      end
      STEP_A_P: begin
        mul_a = $signed(MUL_W'(gain_i));
        mul_b = MUL_W'(cur_integ);
      end
      STEP_A_I: begin
        mul_a = $signed(MUL_W'(gain_d));
        mul_b = MUL_W'(diff);
      end
      STEP_D_SCALE: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(MS_SQ);
      end
      STEP_B: begin
        mul_a = $signed({2'b00, acc_a[31:0]});
        mul_b = d_op;
      end
      STEP_N_LO: begin
        mul_a = MUL_W'($signed(acc_a[A_W-1:32]));
        mul_b = d_op;
      end
      STEP_N_HI: begin
        mul_a = MUL_W'(DRIVE_DEN);
        mul_b = d_op;
      end
      default: ;
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Integral update and clamp
  always_comb begin
    isum  = INS_W'(cur_integ) + $signed(prod[INS_W-1:0]);
    lim_s = $signed(INS_W'(lim));
    if (isum > lim_s) begin
      integ_clamp = lim_s;
    end else if (isum < -lim_s) begin
      integ_clamp = -lim_s;
    end else begin
      integ_clamp = isum;
    end
  end

  assign div_ge = $unsigned(nacc) >= ACC_W'(dv);

  always_comb begin
    if (neg) begin
      sat_val = drive_min;
    end else if (over) begin
      sat_val = drive_max;
    end else if (q < drive_min) begin
      sat_val = drive_min;
    end else if (q > drive_max) begin
      sat_val = drive_max;
    end else begin
      sat_val = q;
    end
  end

  // Control, configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= STEP_START;
      wheel          <= 1'b0;
      result_valid   <= 1'b0;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      integral_limit <= INT_LIMIT_RST;
      drive_min      <= DRIVE_MIN_RST;
      drive_max      <= DRIVE_MAX_RST;
      last_time      <= '0;
      integ[0]       <= '0;
      integ[1]       <= '0;
      prev[0]        <= '0;
      prev[1]        <= '0;
      held[0]        <= '0;
      held[1]        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P:    gain_p         <= cfg_data;
          REG_GAIN_I:    gain_i         <= cfg_data;
          REG_GAIN_D:    gain_d         <= cfg_data;
          REG_INT_LIMIT: integral_limit <= cfg_data[14:0];
          REG_DRIVE_MIN: drive_min      <= cfg_data[7:0];
          REG_DRIVE_MAX: drive_max      <= cfg_data[7:0];
          default: ;
        endcase
      end

      // load a finished word, else drop the one just taken
      if (state == ST_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_time <= item.time_ms;
            wheel     <= 1'b0;
            step      <= STEP_START;
            if (item.kind) begin
              integ[0] <= '0;
              integ[1] <= '0;
              prev[0]  <= '0;
              prev[1]  <= '0;
              state    <= ST_EMIT;
            end else begin
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (step == STEP_INTEG) begin
            integ[wheel] <= integ_clamp[INT_W-1:0];
          end
          if (step == STEP_SAT) begin
            held[wheel] <= sat_val;
            prev[wheel] <= cur_err;
            step        <= STEP_START;
            if (wheel) begin
              state <= ST_EMIT;
            end else begin
              wheel <= 1'b1;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_EMIT: begin
          // hold the finished word until the result register drains
          if (!result_valid || result_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (accept) begin
      d      <= d_in;
      lim    <= LIM_W'(integral_limit * MS_PER_S);
      err[0] <= err_in_l;
      err[1] <= err_in_r;
    end
    if (state == ST_CALC) begin
      unique case (step)
        STEP_START, STEP_INTEG, STEP_KP, STEP_D_SCALE, STEP_SAT: ;
        STEP_A_P:   acc_a <= $signed(prod[A_W-1:0]);
        STEP_A_I:   acc_a <= acc_a + $signed(prod[A_W-1:0]);
        STEP_B:     nacc  <= ACC_W'(prod);
        STEP_N_LO:  nacc  <= nacc + ACC_W'(prod);
        STEP_N_HI:  nacc  <= nacc + ACC_W'($signed({prod[45:0], 32'd0}));
        STEP_DEN:   dv    <= {1'b0, prod[57:0], 7'd0};
        STEP_RANGE: begin
          neg  <= nacc[ACC_W-1];
          over <= $unsigned(nacc) >= ACC_W'({dv, 1'b0});
          q    <= '0;
        end
        default: begin
          // one quotient bit per cycle, divisor walks down from D shifted by 7
          if (div_ge) begin
            nacc <= nacc - $signed(ACC_W'(dv));
            q    <= {q[6:0], 1'b1};
          end else begin
            q <= {q[6:0], 1'b0};
          end
          dv <= dv >> 1;
        end
      endcase
    end
    if (state == ST_EMIT && (!result_valid || result_ready)) begin
      result.drive_left  <= held[0];
      result.drive_right <= held[1];
    end
  end

endmodule

`default_nettype wire
